// File: hdl/pblt_pkg.sv
// Shared types, constants and character helpers for the prefix block list table.
`default_nettype none

package pblt_pkg;

  // Default number of table cells
  localparam int unsigned TABLE_DEPTH = 16;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ENTRY_W = 3 * CHAR_W;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned INDEX_W = 8;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Command codes of one item
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } pblt_cmd_e;

  // Per-item update strobes broadcast along the cell row
  typedef struct packed {
    logic append;
    logic remove;
  } pblt_ctrl_t;

  function automatic logic is_letter(input char_t c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic char_t upcase(input char_t c);
    if ((c >= 8'h61) && (c <= 8'h7A)) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pblt_cell.sv
// One table cell: holds one entry, compares it, and takes its upper neighbor on removal.
`default_nettype none

module pblt_cell #(
  parameter int unsigned Pos  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                               clk_i,
  input  pblt_pkg::pblt_ctrl_t               ctrl_i,
  input  logic [CntW-1:0]                    count_i,
  input  logic [pblt_pkg::INDEX_W-1:0]       index_i,
  input  pblt_pkg::entry_t                   key_i,
  input  pblt_pkg::entry_t                   next_i,
  output pblt_pkg::entry_t                   entry_o,
  output logic                               match_o,
  output pblt_pkg::entry_t                   rd_o
);
  import pblt_pkg::*;

  entry_t entry_q;
  entry_t entry_d;
  logic   occupied;
  logic   shift_en;
  logic   load_en;

  // Decide occupancy from the shared count
  assign occupied = INDEX_W'(Pos) < INDEX_W'(count_i);

  // Compare against the broadcast key and select for read
  assign match_o = occupied && (entry_q == key_i);
  assign rd_o    = (occupied && (INDEX_W'(Pos) == index_i)) ? entry_q : '0;

  // Shift down on remove, load at the fill position on append
  assign shift_en = ctrl_i.remove && (INDEX_W'(Pos) >= index_i) &&
                    ((9'(Pos) + 9'd1) < 9'(count_i));
  assign load_en  = ctrl_i.append && (INDEX_W'(Pos) == INDEX_W'(count_i));

  always_comb begin
    entry_d = entry_q;
    if (shift_en) begin
      entry_d = next_i;
    end else if (load_en) begin
      entry_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: hdl/prefix_block_list_table.sv
// Top level of the prefix block list table: key shaping, cell row, count and result register.
//
// Usage: one item per command on the input channel (cmd, three key characters, index),
// one result item per command on the output channel (flag, entry count, three entry
// characters). An item is taken when in_valid_i is high and in_stall_o is low; a result
// is taken when out_valid_o is high and out_stall_i is low.
// Output: the result is registered and appears in the cycle after the item is taken.
// Throughput: one item per cycle while no held result stalls the input. Every cell compares
// its entry against the key in the same cycle, and on remove each cell from the index up loads
// its upper neighbor, so no command needs more than the one pass through the cell row.
// Stall: a result held by out_stall_i stays unchanged in the output register; the
// input is stalled while a held result waits and is released in the cycle it is taken.
// Reset: rst_ni clears the entry count and the output valid; cell contents are
// undefined until added and are never shown beyond the count.
`default_nettype none

module prefix_block_list_table #(
  parameter int unsigned TableDepth = pblt_pkg::TABLE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           cmd_i,
  input  pblt_pkg::char_t                      key_char0_i,
  input  pblt_pkg::char_t                      key_char1_i,
  input  pblt_pkg::char_t                      key_char2_i,
  input  logic [pblt_pkg::INDEX_W-1:0]         index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 flag_o,
  output logic [pblt_pkg::COUNT_OUT_W-1:0]     entry_count_o,
  output pblt_pkg::char_t                      entry_char0_o,
  output pblt_pkg::char_t                      entry_char1_o,
  output pblt_pkg::char_t                      entry_char2_o
);
  import pblt_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  pblt_cmd_e       cmd;
  logic            accept;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            l0, l1, l2;
  logic            a0, a1, a2;
  entry_t          lk_key;
  entry_t          add_key;
  entry_t          key;
  logic            hit;
  logic            in_range;
  logic            not_full;
  entry_t          rd_data;
  pblt_ctrl_t      ctrl;
  logic            flag_d;

  logic            out_valid_q;
  logic            out_valid_d;
  logic            flag_q;
  logic [COUNT_OUT_W-1:0] count_out_q;
  entry_t          rd_q;

  entry_t          cell_entry [TableDepth];
  entry_t          cell_rd    [TableDepth];
  logic [TableDepth-1:0] match_vec;

  assign cmd    = pblt_cmd_e'(cmd_i);
  assign accept = in_valid_i && !in_stall_o;

  // Hold the input while a result waits to be taken
  assign in_stall_o = out_valid_q && out_stall_i;

  // Shape the lookup key: leading letters only
  assign l0 = is_letter(key_char0_i);
  assign l1 = l0 && is_letter(key_char1_i);
  assign l2 = l1 && is_letter(key_char2_i);
  assign lk_key = {l0 ? upcase(key_char0_i) : 8'h00,
                   l1 ? upcase(key_char1_i) : 8'h00,
                   l2 ? upcase(key_char2_i) : 8'h00};

  // Shape the add key: up to the first zero byte
  assign a0 = key_char0_i != 8'h00;
  assign a1 = a0 && (key_char1_i != 8'h00);
  assign a2 = a1 && (key_char2_i != 8'h00);
  assign add_key = {a0 ? upcase(key_char0_i) : 8'h00,
                    a1 ? upcase(key_char1_i) : 8'h00,
                    a2 ? upcase(key_char2_i) : 8'h00};

  assign key = (cmd == CMD_LOOKUP) ? lk_key : add_key;

  // Row of cells, each fed by its upper neighbor
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    entry_t next;
    if (i + 1 < TableDepth) begin : g_mid
      assign next = cell_entry[i+1];
    end else begin : g_last
      assign next = '0;
    end
    pblt_cell #(
      .Pos  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .index_i (index_i),
      .key_i   (key),
      .next_i  (next),
      .entry_o (cell_entry[i]),
      .match_o (match_vec[i]),
      .rd_o    (cell_rd[i])
    );
  end

  assign hit = |match_vec;

  // Merge the read data; at most one cell drives a nonzero value
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < TableDepth; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  assign in_range = index_i < INDEX_W'(count_q);
  assign not_full = 9'(count_q) < 9'(TableDepth);

  // Decode the command into update strobes, flag and next count
  always_comb begin
    ctrl    = '0;
    flag_d  = 1'b0;
    count_d = count_q;
    unique case (cmd)
      CMD_LOOKUP: begin
        flag_d = l0 && hit;
      end
      CMD_ADD: begin
        flag_d = not_full && a0;
        if (not_full && a0 && !hit) begin
          ctrl.append = accept;
          if (accept) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (in_range) begin
          ctrl.remove = accept;
          if (accept) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      CMD_READ: begin
        flag_d = in_range;
      end
      default: begin
        flag_d = 1'b0;
      end
    endcase
  end

  // Advance the output valid: load on accept, keep while stalled
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result payload of an accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flag_q      <= flag_d;
      count_out_q <= COUNT_OUT_W'(count_d);
      rd_q        <= (cmd == CMD_READ) ? rd_data : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign flag_o        = flag_q;
  assign entry_count_o = count_out_q;
  assign entry_char0_o = rd_q[23:16];
  assign entry_char1_o = rd_q[15:8];
  assign entry_char2_o = rd_q[7:0];

endmodule

`default_nettype wire

// File: hdl/pblt_checker.sv
// Port-level checks of the prefix block list table and their binding to the top level.
`default_nettype none

module pblt_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 flag_o,
  input logic [pblt_pkg::COUNT_OUT_W-1:0]     entry_count_o,
  input pblt_pkg::char_t                      entry_char0_o,
  input pblt_pkg::char_t                      entry_char1_o,
  input pblt_pkg::char_t                      entry_char2_o
);
  import pblt_pkg::*;

  // A taken item yields its result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("result missing one cycle after an accepted item");

  // A held result stays and does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(flag_o) &&
      $stable(entry_count_o) && $stable(entry_char0_o) &&
      $stable(entry_char1_o) && $stable(entry_char2_o)))
    else $error("stalled result changed");

  // Entry characters show only with a set flag
  a_chars_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !flag_o) |->
      (entry_char0_o == 8'h00 && entry_char1_o == 8'h00 && entry_char2_o == 8'h00))
    else $error("entry characters without flag");

  // A zero byte ends a stored entry
  a_zero_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (entry_char0_o == 8'h00 || entry_char1_o == 8'h00)) |->
      (entry_char2_o == 8'h00 && (entry_char0_o != 8'h00 || entry_char1_o == 8'h00)))
    else $error("entry characters after a zero byte");

endmodule

bind prefix_block_list_table pblt_checker u_pblt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .flag_o        (flag_o),
  .entry_count_o (entry_count_o),
  .entry_char0_o (entry_char0_o),
  .entry_char1_o (entry_char1_o),
  .entry_char2_o (entry_char2_o)
);

`default_nettype wire

// File: verif/tb_prefix_block_list_table.sv
// Self-checking testbench for the prefix block list table: directed probes, then random traffic.
`timescale 1ns / 100ps

module tb_prefix_block_list_table;
  import pblt_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH;
  localparam int unsigned PROBE_ROWS   = 25;
  localparam int unsigned CHUNK_ITEMS  = 100;
  localparam int unsigned CHUNKS       = 15;
  localparam int unsigned QUIET_CHUNKS = 2;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Character values around the letter ranges
  localparam char_t BORDER_CHARS [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_e;

  // One prefix, element 0 holds the first character
  typedef logic [2:0][CHAR_W-1:0] prefix_t;

  typedef struct packed {
    logic                   flag;
    logic [COUNT_OUT_W-1:0] count;
    char_t                  ch0;
    char_t                  ch1;
    char_t                  ch2;
  } prefix_res_t;

  typedef struct {
    bit          typed;
    prefix_res_t res;
  } fixed_res_t;

  typedef struct {
    pblt_cmd_e          op;
    char_t              k0;
    char_t              k1;
    char_t              k2;
    logic [INDEX_W-1:0] idx;
    bit                 typed;
    prefix_res_t        res;
  } probe_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [1:0]             cmd_i;
  char_t                  key_char0_i;
  char_t                  key_char1_i;
  char_t                  key_char2_i;
  logic [INDEX_W-1:0]     index_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   flag_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;
  char_t                  entry_char0_o;
  char_t                  entry_char1_o;
  char_t                  entry_char2_o;

  // Table shadow kept by the predictor
  prefix_t prefix_mem [DEPTH];
  int      fill_cnt;

  prefix_res_t result_q [$];
  fixed_res_t  fixed_q [$];

  bit idle_in_on;
  bit idle_out_on;
  int err_cnt;
  int n_items;
  int n_results;
  int n_hits;
  int n_full_refusals;
  int peak_fill;

  // Directed probes; typed results only where obvious
  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'd0,   1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00}},
    '{CMD_REMOVE, 8'h00, 8'h00, 8'h00, 8'd0,   1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00}},
    '{CMD_LOOKUP, "A",   "B",   "C",   8'd0,   1'b1, '{1'b0, 5'd0, 8'h00, 8'h00, 8'h00}},
    '{CMD_ADD,    "a",   "b",   "c",   8'd0,   1'b1, '{1'b1, 5'd1, 8'h00, 8'h00, 8'h00}},
    '{CMD_ADD,    8'h00, "X",   "Y",   8'd0,   1'b1, '{1'b0, 5'd1, 8'h00, 8'h00, 8'h00}},
    '{CMD_ADD,    "A",   "B",   "C",   8'd0,   1'b1, '{1'b1, 5'd1, 8'h00, 8'h00, 8'h00}},
    '{CMD_ADD,    8'hFF, 8'h00, 8'h7F, 8'd0,   1'b1, '{1'b1, 5'd2, 8'h00, 8'h00, 8'h00}},
    '{CMD_ADD,    "z",   8'h00, "Q",   8'd0,   1'b1, '{1'b1, 5'd3, 8'h00, 8'h00, 8'h00}},
    '{CMD_ADD,    "1",   "a",   "~",   8'd0,   1'b1, '{1'b1, 5'd4, 8'h00, 8'h00, 8'h00}},
    '{CMD_LOOKUP, "a",   "B",   "c",   8'd0,   1'b1, '{1'b1, 5'd4, 8'h00, 8'h00, 8'h00}},
    '{CMD_LOOKUP, "Z",   "1",   "x",   8'd0,   1'b0, '0},
    '{CMD_LOOKUP, 8'hFF, 8'h00, 8'h00, 8'd0,   1'b1, '{1'b0, 5'd4, 8'h00, 8'h00, 8'h00}},
    '{CMD_LOOKUP, 8'h40, "A",   "A",   8'd0,   1'b0, '0},
    '{CMD_LOOKUP, 8'h7B, "a",   "b",   8'd0,   1'b0, '0},
    '{CMD_LOOKUP, "z",   8'h5B, "a",   8'd0,   1'b0, '0},
    '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'd1,   1'b1, '{1'b1, 5'd4, 8'hFF, 8'h00, 8'h00}},
    '{CMD_READ,   8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b1, '{1'b0, 5'd4, 8'h00, 8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'd4,   1'b1, '{1'b0, 5'd4, 8'h00, 8'h00, 8'h00}},
    '{CMD_REMOVE, 8'h00, 8'h00, 8'h00, 8'd0,   1'b1, '{1'b0, 5'd3, 8'h00, 8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'd0,   1'b0, '0},
    '{CMD_LOOKUP, "A",   "B",   "C",   8'd0,   1'b0, '0},
    '{CMD_REMOVE, 8'h00, 8'h00, 8'h00, 8'd2,   1'b0, '0},
    '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'd2,   1'b0, '0},
    '{CMD_ADD,    8'hFF, 8'hFF, 8'hFF, 8'd0,   1'b1, '{1'b1, 5'd3, 8'h00, 8'h00, 8'h00}},
    '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'd2,   1'b1, '{1'b1, 5'd3, 8'hFF, 8'hFF, 8'hFF}}
  };

  prefix_block_list_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .key_char0_i   (key_char0_i),
    .key_char1_i   (key_char1_i),
    .key_char2_i   (key_char2_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .flag_o        (flag_o),
    .entry_count_o (entry_count_o),
    .entry_char0_o (entry_char0_o),
    .entry_char1_o (entry_char1_o),
    .entry_char2_o (entry_char2_o)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_alpha(char_t c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic char_t to_upper(char_t c);
    return ((c >= "a") && (c <= "z")) ? char_t'(c - 8'h20) : c;
  endfunction

  function automatic bit holds_prefix(prefix_t key);
    for (int i = 0; i < fill_cnt; i++) begin
      if (prefix_mem[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Predict the result of one item and advance the table shadow
  function automatic prefix_res_t apply_prefix_cmd(pblt_cmd_e op, char_t k0, char_t k1,
                                                   char_t k2, logic [INDEX_W-1:0] idx);
    prefix_res_t r;
    prefix_t     raw;
    prefix_t     key;
    int          n;
    bit          stop;
    r    = '0;
    key  = '0;
    n    = 0;
    stop = 1'b0;
    raw[0] = k0;
    raw[1] = k1;
    raw[2] = k2;
    case (op)
      CMD_LOOKUP: begin
        // keep leading letters only
        for (int i = 0; i < 3; i++) begin
          if (!stop && is_alpha(raw[i])) begin
            key[i] = to_upper(raw[i]);
            n++;
          end else begin
            stop = 1'b1;
          end
        end
        r.flag = (n > 0) && holds_prefix(key);
        if (r.flag) n_hits++;
      end
      CMD_ADD: begin
        // keep everything up to the first zero
        for (int i = 0; i < 3; i++) begin
          if (!stop && raw[i] != 8'h00) begin
            key[i] = to_upper(raw[i]);
            n++;
          end else begin
            stop = 1'b1;
          end
        end
        if (fill_cnt >= DEPTH) begin
          n_full_refusals++;
        end else if (n > 0) begin
          r.flag = 1'b1;
          if (!holds_prefix(key)) begin
            prefix_mem[fill_cnt] = key;
            fill_cnt++;
          end
        end
      end
      CMD_REMOVE: begin
        if (idx < fill_cnt) begin
          for (int i = idx; i + 1 < fill_cnt; i++) prefix_mem[i] = prefix_mem[i + 1];
          fill_cnt--;
        end
      end
      default: begin
        if (idx < fill_cnt) begin
          r.flag = 1'b1;
          r.ch0  = prefix_mem[idx][0];
          r.ch1  = prefix_mem[idx][1];
          r.ch2  = prefix_mem[idx][2];
        end
      end
    endcase
    r.count = fill_cnt[COUNT_OUT_W-1:0];
    if (fill_cnt > peak_fill) peak_fill = fill_cnt;
    return r;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // Sample both channels mid-cycle; queue expectations, then check results
  always @(negedge clk_i) begin : result_check
    fixed_res_t  fr;
    prefix_res_t want;
    prefix_res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        n_items++;
        want = apply_prefix_cmd(pblt_cmd_e'(cmd_i), key_char0_i, key_char1_i, key_char2_i,
                                index_i);
        if (fixed_q.size() != 0) begin
          fr = fixed_q.pop_front();
          if (fr.typed) want = fr.res;
        end
        result_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        got = '{flag_o, entry_count_o, entry_char0_o, entry_char1_o, entry_char2_o};
        if (result_q.size() == 0) begin
          $display("%0t: result item with nothing expected, actual %0h", $time, got);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          check_field("flag", 8'(want.flag), 8'(got.flag));
          check_field("entry_count", 8'(want.count), 8'(got.count));
          check_field("entry_char0", want.ch0, got.ch0);
          check_field("entry_char1", want.ch1, got.ch1);
          check_field("entry_char2", want.ch2, got.ch2);
        end
      end
    end
  end

  // Hold the item until taken; sometimes idle for a random burst first
  task automatic send_item(pblt_cmd_e op, char_t k0, char_t k1, char_t k2,
                           logic [INDEX_W-1:0] idx, bit typed, prefix_res_t res);
    bit taken;
    if (idle_in_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    fixed_q.push_back('{typed, res});
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    key_char0_i <= k0;
    key_char1_i <= k1;
    key_char2_i <= k2;
    index_i     <= idx;
    do begin
      @(negedge clk_i);
      taken = in_valid_i && !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic char_t rand_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return char_t'(8'h41 + $urandom_range(0, 2)) | char_t'($urandom_range(0, 1) << 5);
      6:       return 8'h00;
      7:       return char_t'($urandom_range(0, 255));
      8:       return BORDER_CHARS[$urandom_range(0, 7)];
      default: return char_t'(8'h41 + $urandom_range(0, 25)) | char_t'($urandom_range(0, 1) << 5);
    endcase
  endfunction

  function automatic pblt_cmd_e pick_op(traffic_mix_e mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        return (roll < 60) ? CMD_ADD : (roll < 80) ? CMD_LOOKUP : (roll < 90) ? CMD_READ : CMD_REMOVE;
      MIX_DRAIN:
        return (roll < 50) ? CMD_REMOVE : (roll < 70) ? CMD_READ : (roll < 90) ? CMD_LOOKUP : CMD_ADD;
      default:
        return (roll < 25) ? CMD_LOOKUP : (roll < 50) ? CMD_ADD : (roll < 75) ? CMD_REMOVE : CMD_READ;
    endcase
  endfunction

  // Stall the result side in random bursts
  initial begin : stall_gen
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && idle_out_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    traffic_mix_e       mix;
    pblt_cmd_e          op;
    prefix_t            k;
    prefix_t            pick;
    logic [INDEX_W-1:0] idx;
    bit                 quiet;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_LOOKUP;
    key_char0_i <= 8'h00;
    key_char1_i <= 8'h00;
    key_char2_i <= 8'h00;
    index_i     <= 8'd0;
    idle_in_on  = 1'b1;
    idle_out_on = 1'b1;
    fill_cnt    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed probes
    foreach (probe_rows[i]) begin
      send_item(probe_rows[i].op, probe_rows[i].k0, probe_rows[i].k1, probe_rows[i].k2,
                probe_rows[i].idx, probe_rows[i].typed, probe_rows[i].res);
    end

    // Random traffic in chunks that fill, drain or churn the table
    for (int c = 0; c < CHUNKS; c++) begin
      mix         = (c == 0) ? MIX_FILL : traffic_mix_e'($urandom_range(0, 2));
      quiet       = (c >= CHUNKS - QUIET_CHUNKS);
      idle_in_on  = !quiet && ($urandom_range(0, 3) != 0);
      idle_out_on = !quiet && ($urandom_range(0, 3) != 0);
      for (int j = 0; j < CHUNK_ITEMS; j++) begin
        op = pick_op(mix);
        for (int b = 0; b < 3; b++) k[b] = rand_char();
        // reuse a stored prefix in random case to hit and duplicate
        if ((op == CMD_LOOKUP || op == CMD_ADD) && fill_cnt > 0 && $urandom_range(0, 1)) begin
          pick = prefix_mem[$urandom_range(0, fill_cnt - 1)];
          for (int b = 0; b < 3; b++) begin
            k[b] = (is_alpha(pick[b]) && $urandom_range(0, 1)) ? (pick[b] | 8'h20) : pick[b];
          end
          if (pick[1] == 8'h00) k[2] = rand_char();
        end
        idx = ($urandom_range(0, 6) == 0) ? INDEX_W'($urandom_range(0, 255))
                                           : INDEX_W'($urandom_range(0, fill_cnt));
        send_item(op, k[0], k[1], k[2], idx, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results
    while (result_q.size() != 0 || fixed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d items and checked %0d results: %0d lookup hits,", n_items, n_results,
             n_hits);
    $display("%0d adds refused on a full table, peak fill %0d of %0d.", n_full_refusals,
             peak_fill, DEPTH);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop on a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
